### hw/rtl/fgpe_pkg.sv
`default_nettype none

package fgpe_pkg;

    localparam int FONT_BYTES_DEF      = 4096;
    localparam int MAX_GLYPH_BYTES_DEF = 64;

    localparam int COLOR_W  = 16;
    localparam int ROWB_W   = 4;
    localparam int HEIGHT_W = 7;
    localparam int CODE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int SADDR_W  = 12;
    localparam int SIZE_W   = ROWB_W + HEIGHT_W;
    localparam int BASE_W   = CODE_W + SIZE_W;
    localparam int SUM_W    = BASE_W + 1;
    localparam int STEP_W   = 3;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_FG_COLOR   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BG_COLOR   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW_BYTES  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_CODE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_CNT  = 3'd5;

    localparam logic            REQ_LOAD   = 1'b0;
    localparam logic            REQ_RENDER = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [SADDR_W-1:0] store_addr;
        logic [7:0]         store_byte;
        logic [CODE_W-1:0]  char_code;
    } s_data_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pix0;
        logic [COLOR_W-1:0] pix1;
        logic [COLOR_W-1:0] pix2;
        logic [COLOR_W-1:0] pix3;
        logic [COLOR_W-1:0] pix4;
        logic [COLOR_W-1:0] pix5;
        logic [COLOR_W-1:0] pix6;
        logic [COLOR_W-1:0] pix7;
        logic               last;
        logic               bad_char;
    } m_data_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_CHECK,
        ST_MUL,
        ST_READ,
        ST_DATA,
        ST_BAD
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/font_glyph_pixel_expander.sv
// Load beat: the byte is written to the font store at the edge on which the beat is accepted.
// Render beat: the glyph size, then the base, both by shift-add on one adder, then for each
// glyph byte a store read and an output load; the load waits while the output is held.
// A bad character gives its single beat after the glyph size check.
// Synchronous active-low reset restores the header registers; the font store is not cleared.

`default_nettype none

module font_glyph_pixel_expander
    import fgpe_pkg::*;
#(
    parameter int FONT_BYTES      = FONT_BYTES_DEF,
    parameter int MAX_GLYPH_BYTES = MAX_GLYPH_BYTES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire s_data_t            s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output m_data_t                 m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int AW    = $clog2(FONT_BYTES);
    localparam int IDX_W = $clog2(MAX_GLYPH_BYTES);
    localparam logic [STEP_W-1:0] SIZE_LAST = STEP_W'(ROWB_W - 1);
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(CODE_W - 1);

    logic [COLOR_W-1:0]  fg_color_reg;
    logic [COLOR_W-1:0]  bg_color_reg;
    logic [ROWB_W-1:0]   row_bytes_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CODE_W-1:0]   first_code_reg;
    logic [COUNT_W-1:0]  glyph_count_reg;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [BASE_W-1:0]   acc_reg, acc_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [CODE_W-1:0]   rel_reg, rel_next;
    logic [IDX_W-1:0]    emit_m1_reg, emit_m1_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    m_data_t             out_data_reg, out_data_next;

    logic                cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                s_acc;
    logic                out_free;
    logic                out_load;
    logic [SUM_W-1:0]    alu_a, alu_b, alu_sum;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [7:0]          ram_rdata;
    logic [CODE_W-1:0]   rel_c;
    logic [SIZE_W-1:0]   size_c;
    logic                bad_c;
    logic                last_c;
    m_data_t             pix_beat;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg    <= 16'hFFFF;
            bg_color_reg    <= '0;
            row_bytes_reg   <= ROWB_W'(1);
            height_reg      <= HEIGHT_W'(12);
            first_code_reg  <= CODE_W'(32);
            glyph_count_reg <= COUNT_W'(95);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FG_COLOR:   fg_color_reg    <= pwdata[COLOR_W-1:0];
                REG_BG_COLOR:   bg_color_reg    <= pwdata[COLOR_W-1:0];
                REG_ROW_BYTES:  row_bytes_reg   <= pwdata[ROWB_W-1:0];
                REG_HEIGHT:     height_reg      <= pwdata[HEIGHT_W-1:0];
                REG_FIRST_CODE: first_code_reg  <= pwdata[CODE_W-1:0];
                REG_GLYPH_CNT:  glyph_count_reg <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FG_COLOR:   prdata = PDATA_W'(fg_color_reg);
            REG_BG_COLOR:   prdata = PDATA_W'(bg_color_reg);
            REG_ROW_BYTES:  prdata = PDATA_W'(row_bytes_reg);
            REG_HEIGHT:     prdata = PDATA_W'(height_reg);
            REG_FIRST_CODE: prdata = PDATA_W'(first_code_reg);
            REG_GLYPH_CNT:  prdata = PDATA_W'(glyph_count_reg);
            default:        prdata = '0;
        endcase
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign rel_c  = code_reg - first_code_reg;
    assign size_c = acc_reg[SIZE_W-1:0];
    assign bad_c  = (code_reg < first_code_reg) || ({1'b0, rel_c} >= glyph_count_reg)
                    || (size_c == '0);
    assign last_c = (state_reg == ST_BAD) || (idx_reg == emit_m1_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_data.req_type == REQ_RENDER)) begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                if (step_reg == SIZE_LAST) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = bad_c ? ST_BAD : ST_MUL;
            end
            ST_MUL: begin
                if (step_reg == MUL_LAST) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (out_free) begin
                    state_next = last_c ? ST_IDLE : ST_READ;
                end
            end
            ST_BAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        step_next    = step_reg;
        acc_next     = acc_reg;
        code_next    = code_reg;
        size_next    = size_reg;
        rel_next     = rel_reg;
        emit_m1_next = emit_m1_reg;
        idx_next     = idx_reg;
        alu_a        = SUM_W'(acc_reg);
        alu_b        = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = AW'(s_data.store_addr);
        ram_raddr    = alu_sum[AW-1:0];
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    ram_we    = (s_data.req_type == REQ_LOAD);
                    code_next = s_data.char_code;
                    acc_next  = '0;
                    step_next = '0;
                    idx_next  = '0;
                end
            end
            ST_SIZE: begin
                if (row_bytes_reg[step_reg[1:0]]) begin
                    alu_b = SUM_W'(height_reg) << step_reg[1:0];
                end
                acc_next  = alu_sum[BASE_W-1:0];
                step_next = step_reg + 1'b1;
            end
            ST_CHECK: begin
                size_next = size_c;
                rel_next  = rel_c;
                if (size_c > SIZE_W'(MAX_GLYPH_BYTES)) begin
                    emit_m1_next = IDX_W'(MAX_GLYPH_BYTES - 1);
                end else begin
                    emit_m1_next = IDX_W'(size_c - 1'b1);
                end
                acc_next  = '0;
                step_next = '0;
            end
            ST_MUL: begin
                if (rel_reg[step_reg]) begin
                    alu_b = SUM_W'(size_reg) << step_reg;
                end
                acc_next  = alu_sum[BASE_W-1:0];
                step_next = step_reg + 1'b1;
            end
            ST_READ: begin
                alu_b  = SUM_W'(idx_reg);
                ram_re = 1'b1;
            end
            ST_DATA: begin
                if (out_free) begin
                    out_load = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_BAD: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = pix_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        code_reg     <= code_next;
        size_reg     <= size_next;
        rel_reg      <= rel_next;
        emit_m1_reg  <= emit_m1_next;
        out_data_reg <= out_data_next;
    end

    fgpe_alu u_alu (
        .a_i   (alu_a),
        .b_i   (alu_b),
        .sum_o (alu_sum)
    );

    fgpe_ram #(
        .WIDTH (8),
        .DEPTH (FONT_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.store_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fgpe_pixmap u_pixmap (
        .glyph_byte (ram_rdata),
        .fg_color   (fg_color_reg),
        .bg_color   (bg_color_reg),
        .last       (last_c),
        .bad        (state_reg == ST_BAD),
        .beat       (pix_beat)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.req_type == REQ_RENDER)) |=> !s_ready)
        else $error("render beat accepted but block still ready");

    a_bad_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bad_char) |-> (m_data.last && (m_data.pix0 == '0)
                                          && (m_data.pix7 == '0)))
        else $error("bad character beat without last or with pixels");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DATA) || (state_reg == ST_READ)) |-> (idx_reg <= emit_m1_reg))
        else $error("glyph byte index ran past the glyph end");

endmodule

`default_nettype wire

### hw/rtl/fgpe_ram.sv
`default_nettype none

module fgpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fgpe_alu.sv
`default_nettype none

module fgpe_alu
    import fgpe_pkg::*;
(
    input  wire logic [SUM_W-1:0] a_i,
    input  wire logic [SUM_W-1:0] b_i,
    output logic      [SUM_W-1:0] sum_o
);

    assign sum_o = a_i + b_i;

endmodule

`default_nettype wire

### hw/rtl/fgpe_pixmap.sv
`default_nettype none

module fgpe_pixmap
    import fgpe_pkg::*;
(
    input  wire logic [7:0]         glyph_byte,
    input  wire logic [COLOR_W-1:0] fg_color,
    input  wire logic [COLOR_W-1:0] bg_color,
    input  wire logic               last,
    input  wire logic               bad,
    output m_data_t                 beat
);

    logic [COLOR_W-1:0] pix [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (bad) begin
                pix[k] = '0;
            end else if (glyph_byte[7-k]) begin
                pix[k] = fg_color;
            end else begin
                pix[k] = bg_color;
            end
        end
        beat.pix0     = pix[0];
        beat.pix1     = pix[1];
        beat.pix2     = pix[2];
        beat.pix3     = pix[3];
        beat.pix4     = pix[4];
        beat.pix5     = pix[5];
        beat.pix6     = pix[6];
        beat.pix7     = pix[7];
        beat.last     = last;
        beat.bad_char = bad;
    end

endmodule

`default_nettype wire
